@@ src/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the vector unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define V3_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The expression must never hold.
`define V3_ASSERT_NEVER(label, clk, rst, expr, msg) \
   `V3_ASSERT_IMP(label, clk, rst, 1'b1, !(expr), msg)

`endif

@@ src/v3alu_pkg.sv @@
// Types, constants and the arctangent table of the 3D vector unit.
package v3alu_pkg;

   typedef enum logic [1:0] {
      OP_DOT   = 2'd0,
      OP_CROSS = 2'd1,
      OP_NORM  = 2'd2,
      OP_ANGLE = 2'd3
   } op_type;

   localparam int FRONT_LAT = 8;
   localparam int ISQ_LAT   = 32;
   localparam int COR_ITER  = 30;
   localparam int COR_LAT   = COR_ITER + 2;
   localparam int TOTAL_LAT = FRONT_LAT + ISQ_LAT + COR_LAT + 1;

   localparam int OUT_W   = 33;
   localparam int NORM_W  = 25;
   localparam int ANGLE_W = 18;
   localparam int XY_W    = 52;
   localparam int Z_W     = 34;

   localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic [ANGLE_W-1:0]    PI_Q16      = 18'd205887;

   // Per-beat information that rides alongside the square root and CORDIC.
   typedef struct packed {
      op_type                    op;
      logic                      err;
      logic signed [OUT_W-1:0]   dot;
      logic signed [OUT_W-1:0]   cx;
      logic signed [OUT_W-1:0]   cy;
      logic signed [OUT_W-1:0]   cz;
   } side_type;

   // Arctangent of 2^-idx in Q2.30.
   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] v;
      unique case (idx)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;
         5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000008;
         5'd28: v = 32'h00000004;
         5'd29: v = 32'h00000002;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

@@ src/v3alu_front.sv @@
// Front pipeline: products, sums, magnitudes, normalisation and square-root operand.
module v3alu_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     vld_i,
   input  logic [1:0]               opcode_i,
   input  logic signed [15:0]       u_x_i,
   input  logic signed [15:0]       u_y_i,
   input  logic signed [15:0]       u_z_i,
   input  logic signed [15:0]       v_x_i,
   input  logic signed [15:0]       v_y_i,
   input  logic signed [15:0]       v_z_i,
   output logic                     vld_o,
   output v3alu_pkg::side_type      side_o,
   output logic [63:0]              rad_o,
   output logic signed [32:0]       ds_o
);
   import v3alu_pkg::*;

   typedef struct packed {
      op_type             op;
      logic               uzero;
      logic               vzero;
      logic signed [31:0] uxvx, uyvy, uzvz;
      logic signed [31:0] vxvx, vyvy, vzvz;
      logic signed [31:0] uyvz, uzvy, uzvx, uxvz, uxvy, uyvx;
   } s1_type;

   typedef struct packed {
      side_type    side;
      logic [31:0] nv;
   } s2_type;

   typedef struct packed {
      side_type    side;
      logic [31:0] nv;
      logic [31:0] dm;
      logic [31:0] mcx, mcy, mcz;
   } s3_type;

   typedef struct packed {
      side_type    side;
      logic [31:0] nv;
      logic [31:0] dm;
      logic [63:0] sqx, sqy, sqz, sqd;
   } s4_type;

   typedef struct packed {
      side_type    side;
      logic [31:0] nv;
      logic [31:0] dm;
      logic [63:0] c2;
      logic [63:0] p;
   } s5_type;

   typedef struct packed {
      side_type        side;
      logic [31:0]     nv;
      logic [31:0]     dm;
      logic [63:0]     c2;
      logic [3:0]      nz;
      logic [3:0][2:0] lz;
   } s6_type;

   typedef struct packed {
      side_type    side;
      logic [31:0] nv;
      logic [31:0] dm;
      logic [63:0] c2;
      logic [4:0]  k;
   } s7_type;

   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff;
   s3_type s3_in, s3_ff;
   s4_type s4_in, s4_ff;
   s5_type s5_in, s5_ff;
   s6_type s6_in, s6_ff;
   s7_type s7_in, s7_ff;
   side_type           side_in, side_ff;
   logic [63:0]        rad_in, rad_ff;
   logic signed [32:0] ds_in, ds_ff;
   logic [31:0]        dsm;
   logic [FRONT_LAT-1:0] vld_in, vld_ff;

   // Count of leading all-zero bit pairs within one 16-bit chunk.
   function automatic logic [2:0] pair_lz(input logic [15:0] w);
      logic [2:0] n;
      logic       hit;
      n   = 3'd7;
      hit = 1'b0;
      for (int j = 0; j < 8; j++) begin
         if (!hit && (w[15-2*j] || w[14-2*j])) begin
            n   = 3'(j);
            hit = 1'b1;
         end
      end
      return n;
   endfunction

   always_comb begin
      s1_in.op    = op_type'(opcode_i);
      s1_in.uzero = (u_x_i == '0) && (u_y_i == '0) && (u_z_i == '0);
      s1_in.vzero = (v_x_i == '0) && (v_y_i == '0) && (v_z_i == '0);
      s1_in.uxvx  = u_x_i * v_x_i;
      s1_in.uyvy  = u_y_i * v_y_i;
      s1_in.uzvz  = u_z_i * v_z_i;
      s1_in.vxvx  = v_x_i * v_x_i;
      s1_in.vyvy  = v_y_i * v_y_i;
      s1_in.vzvz  = v_z_i * v_z_i;
      s1_in.uyvz  = u_y_i * v_z_i;
      s1_in.uzvy  = u_z_i * v_y_i;
      s1_in.uzvx  = u_z_i * v_x_i;
      s1_in.uxvz  = u_x_i * v_z_i;
      s1_in.uxvy  = u_x_i * v_y_i;
      s1_in.uyvx  = u_y_i * v_x_i;
   end

   always_comb begin
      s2_in.side.op  = s1_ff.op;
      s2_in.side.err = (s1_ff.op == OP_ANGLE) && (s1_ff.uzero || s1_ff.vzero);
      s2_in.side.dot = 33'(s1_ff.uxvx) + 33'(s1_ff.uyvy) + 33'(s1_ff.uzvz);
      s2_in.side.cx  = 33'(s1_ff.uyvz) - 33'(s1_ff.uzvy);
      s2_in.side.cy  = 33'(s1_ff.uzvx) - 33'(s1_ff.uxvz);
      s2_in.side.cz  = 33'(s1_ff.uxvy) - 33'(s1_ff.uyvx);
      s2_in.nv       = $unsigned(s1_ff.vxvx) + $unsigned(s1_ff.vyvy)
                       + $unsigned(s1_ff.vzvz);
   end

   always_comb begin
      s3_in.side = s2_ff.side;
      s3_in.nv   = s2_ff.nv;
      s3_in.dm   = s2_ff.side.dot[32] ? 32'(-s2_ff.side.dot) : s2_ff.side.dot[31:0];
      s3_in.mcx  = s2_ff.side.cx[32] ? 32'(-s2_ff.side.cx) : s2_ff.side.cx[31:0];
      s3_in.mcy  = s2_ff.side.cy[32] ? 32'(-s2_ff.side.cy) : s2_ff.side.cy[31:0];
      s3_in.mcz  = s2_ff.side.cz[32] ? 32'(-s2_ff.side.cz) : s2_ff.side.cz[31:0];
   end

   always_comb begin
      s4_in.side = s3_ff.side;
      s4_in.nv   = s3_ff.nv;
      s4_in.dm   = s3_ff.dm;
      s4_in.sqx  = 64'(s3_ff.mcx) * 64'(s3_ff.mcx);
      s4_in.sqy  = 64'(s3_ff.mcy) * 64'(s3_ff.mcy);
      s4_in.sqz  = 64'(s3_ff.mcz) * 64'(s3_ff.mcz);
      s4_in.sqd  = 64'(s3_ff.dm) * 64'(s3_ff.dm);
   end

   // Sum of squared cross and dot equals |u|^2 |v|^2, so it fits in 64 bits.
   always_comb begin
      s5_in.side = s4_ff.side;
      s5_in.nv   = s4_ff.nv;
      s5_in.dm   = s4_ff.dm;
      s5_in.c2   = s4_ff.sqx + s4_ff.sqy + s4_ff.sqz;
      s5_in.p    = s4_ff.sqx + s4_ff.sqy + s4_ff.sqz + s4_ff.sqd;
   end

   always_comb begin
      s6_in.side = s5_ff.side;
      s6_in.nv   = s5_ff.nv;
      s6_in.dm   = s5_ff.dm;
      s6_in.c2   = s5_ff.c2;
      for (int c = 0; c < 4; c++) begin
         s6_in.nz[c] = (s5_ff.p[16*c +: 16] != '0);
         s6_in.lz[c] = pair_lz(s5_ff.p[16*c +: 16]);
      end
   end

   // The shift count saturates at 31 pairs, which the lowest chunk gives by itself.
   always_comb begin
      s7_in.side = s6_ff.side;
      s7_in.nv   = s6_ff.nv;
      s7_in.dm   = s6_ff.dm;
      s7_in.c2   = s6_ff.c2;
      priority if (s6_ff.nz[3]) begin
         s7_in.k = {2'd0, s6_ff.lz[3]};
      end else if (s6_ff.nz[2]) begin
         s7_in.k = {2'd1, s6_ff.lz[2]};
      end else if (s6_ff.nz[1]) begin
         s7_in.k = {2'd2, s6_ff.lz[1]};
      end else if (s6_ff.nz[0]) begin
         s7_in.k = {2'd3, s6_ff.lz[0]};
      end else begin
         s7_in.k = 5'd31;
      end
   end

   always_comb begin
      side_in = s7_ff.side;
      dsm     = s7_ff.dm << s7_ff.k;
      ds_in   = s7_ff.side.dot[32] ? -$signed(33'(dsm)) : $signed(33'(dsm));
      if (s7_ff.side.op == OP_NORM) begin
         rad_in = {16'd0, s7_ff.nv, 16'd0};
      end else begin
         rad_in = s7_ff.c2 << {s7_ff.k, 1'b0};
      end
   end

   assign vld_in = {vld_ff[FRONT_LAT-2:0], vld_i};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff   <= s1_in;
      s2_ff   <= s2_in;
      s3_ff   <= s3_in;
      s4_ff   <= s4_in;
      s5_ff   <= s5_in;
      s6_ff   <= s6_in;
      s7_ff   <= s7_in;
      side_ff <= side_in;
      rad_ff  <= rad_in;
      ds_ff   <= ds_in;
   end

   assign vld_o  = vld_ff[FRONT_LAT-1];
   assign side_o = side_ff;
   assign rad_o  = rad_ff;
   assign ds_o   = ds_ff;

endmodule

@@ src/v3alu_isqrt.sv @@
// Pipelined 64-bit integer square root, one result bit per stage, rounded down.
module v3alu_isqrt (
   input  logic        clock,
   input  logic [63:0] rad_i,
   output logic [31:0] root_o
);
   import v3alu_pkg::*;

   logic [63:0] n_ff [ISQ_LAT];
   logic [63:0] r_ff [ISQ_LAT];

   for (genvar i = 0; i < ISQ_LAT; i++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
      logic [63:0] n_prev, r_prev, trial, n_in, r_in;

      if (i == 0) begin : g_first
         assign n_prev = rad_i;
         assign r_prev = '0;
      end else begin : g_rest
         assign n_prev = n_ff[i-1];
         assign r_prev = r_ff[i-1];
      end

      always_comb begin
         trial = r_prev + BIT;
         if (n_prev >= trial) begin
            n_in = n_prev - trial;
            r_in = (r_prev >> 1) + BIT;
         end else begin
            n_in = n_prev;
            r_in = r_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         n_ff[i] <= n_in;
         r_ff[i] <= r_in;
      end
   end

   assign root_o = r_ff[ISQ_LAT-1][31:0];

endmodule

@@ src/v3alu_cordic.sv @@
// Pipelined vectoring CORDIC giving atan2 in Q2.16 over the upper half plane.
module v3alu_cordic (
   input  logic                                 clock,
   input  logic signed [32:0]                   ds_i,
   input  logic [31:0]                          cs_i,
   output logic [v3alu_pkg::ANGLE_W-1:0]        angle_o
);
   import v3alu_pkg::*;

   logic signed [XY_W-1:0] px_in, py_in, px_ff, py_ff;
   logic signed [Z_W-1:0]  pz_in, pz_ff;
   logic signed [32:0]     negd;
   logic signed [XY_W-1:0] x_ff [COR_ITER];
   logic signed [XY_W-1:0] y_ff [COR_ITER];
   logic signed [Z_W-1:0]  z_ff [COR_ITER];
   logic signed [Z_W-1:0]  zf, zr;
   logic [19:0]            r20;
   logic [ANGLE_W-1:0]     ang_in, ang_ff;

   // A negative cosine term is turned by a quarter turn first.
   always_comb begin
      negd = -ds_i;
      if (ds_i[32]) begin
         px_in = $signed(52'(cs_i)) <<< 16;
         py_in = 52'(negd) <<< 16;
         pz_in = HALF_PI_Q30;
      end else begin
         px_in = 52'(ds_i) <<< 16;
         py_in = $signed(52'(cs_i)) <<< 16;
         pz_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in;
      py_ff <= py_in;
      pz_ff <= pz_in;
   end

   for (genvar i = 0; i < COR_ITER; i++) begin : g_iter
      localparam logic [31:0] ANG = atan_q30(5'(i));
      logic signed [XY_W-1:0] x_prev, y_prev, x_in, y_in;
      logic signed [Z_W-1:0]  z_prev, z_in;

      if (i == 0) begin : g_first
         assign x_prev = px_ff;
         assign y_prev = py_ff;
         assign z_prev = pz_ff;
      end else begin : g_rest
         assign x_prev = x_ff[i-1];
         assign y_prev = y_ff[i-1];
         assign z_prev = z_ff[i-1];
      end

      always_comb begin
         if (!y_prev[XY_W-1]) begin
            x_in = x_prev + (y_prev >>> i);
            y_in = y_prev - (x_prev >>> i);
            z_in = z_prev + $signed(34'(ANG));
         end else begin
            x_in = x_prev - (y_prev >>> i);
            y_in = y_prev + (x_prev >>> i);
            z_in = z_prev - $signed(34'(ANG));
         end
      end

      always_ff @(posedge clock) begin
         x_ff[i] <= x_in;
         y_ff[i] <= y_in;
         z_ff[i] <= z_in;
      end
   end

   // Round Q2.30 to Q2.16 to nearest and hold the result within [0, pi].
   always_comb begin
      zf  = z_ff[COR_ITER-1];
      zr  = zf + 34'sd8192;
      r20 = 20'(zr >>> 14);
      if (zf[Z_W-1]) begin
         ang_in = '0;
      end else if (r20 > 20'(PI_Q16)) begin
         ang_in = PI_Q16;
      end else begin
         ang_in = r20[ANGLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      ang_ff <= ang_in;
   end

   assign angle_o = ang_ff;

endmodule

@@ src/vector3d_alu.sv @@
// Top level of the 3D vector unit: dot, cross, norm and angle of Q8.8 vectors.
//
// Usage: drive the opcode and the two vectors on the req_ ports and raise
// start; a beat is taken at every rising edge with start high and busy low.
// busy stays low, so a new beat may be taken on every clock cycle.
// Each beat gives one result, which sits on the rsp_ ports for one cycle
// with rsp_valid high. The receiver cannot stall. A beat passes through
// the eight front stages (products, sums, magnitudes, squares and
// normalisation), the 32 stages of the square root unit that resolve one
// root bit each, the 32 stages of the CORDIC (quarter turn, 30 iterations,
// rounding) and the output register. Throughput is one beat per cycle for
// every opcode.
// The zero-vector flag is raised only for the angle opcode, with a zero
// scalar result. Fields without meaning for the opcode read zero.
// Reset is synchronous and clears all valid bits; beats in flight are lost.
`include "assert_macros.svh"

module vector3d_alu (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic signed [15:0] req_u_x,
   input  logic signed [15:0] req_u_y,
   input  logic signed [15:0] req_u_z,
   input  logic signed [15:0] req_v_x,
   input  logic signed [15:0] req_v_y,
   input  logic signed [15:0] req_v_z,
   output logic               rsp_valid,
   output logic signed [32:0] rsp_scalar_result,
   output logic signed [32:0] rsp_cross_x,
   output logic signed [32:0] rsp_cross_y,
   output logic signed [32:0] rsp_cross_z,
   output logic               rsp_zero_vector_error
);
   import v3alu_pkg::*;

   typedef struct packed {
      side_type           side;
      logic signed [32:0] ds;
   } line_a_type;

   typedef struct packed {
      side_type            side;
      logic [NORM_W-1:0]   norm;
   } line_b_type;

   logic                   accept;
   logic                   f_vld;
   side_type               f_side;
   logic [63:0]            f_rad;
   logic signed [32:0]     f_ds;
   logic [31:0]            root;
   logic [ANGLE_W-1:0]     angle;

   logic [ISQ_LAT-1:0]     va_ff;
   line_a_type             la_ff [ISQ_LAT];
   logic [COR_LAT-1:0]     vb_ff;
   line_b_type             lb_ff [COR_LAT];
   line_b_type             fin;

   logic                   valid_in, valid_ff;
   logic signed [32:0]     scalar_in, scalar_ff;
   logic signed [32:0]     cx_in, cx_ff;
   logic signed [32:0]     cy_in, cy_ff;
   logic signed [32:0]     cz_in, cz_ff;
   logic                   err_in, err_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   v3alu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .vld_i    (accept),
      .opcode_i (req_opcode),
      .u_x_i    (req_u_x),
      .u_y_i    (req_u_y),
      .u_z_i    (req_u_z),
      .v_x_i    (req_v_x),
      .v_y_i    (req_v_y),
      .v_z_i    (req_v_z),
      .vld_o    (f_vld),
      .side_o   (f_side),
      .rad_o    (f_rad),
      .ds_o     (f_ds)
   );

   v3alu_isqrt u_isqrt (
      .clock  (clock),
      .rad_i  (f_rad),
      .root_o (root)
   );

   v3alu_cordic u_cordic (
      .clock   (clock),
      .ds_i    (la_ff[ISQ_LAT-1].ds),
      .cs_i    (root),
      .angle_o (angle)
   );

   // Side information follows the square root, then the CORDIC, stage by stage.
   always_ff @(posedge clock) begin
      la_ff[0] <= '{side: f_side, ds: f_ds};
      for (int j = 1; j < ISQ_LAT; j++) begin
         la_ff[j] <= la_ff[j-1];
      end
      lb_ff[0] <= '{side: la_ff[ISQ_LAT-1].side, norm: root[NORM_W-1:0]};
      for (int j = 1; j < COR_LAT; j++) begin
         lb_ff[j] <= lb_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff    <= '0;
         vb_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         va_ff    <= {va_ff[ISQ_LAT-2:0], f_vld};
         vb_ff    <= {vb_ff[COR_LAT-2:0], va_ff[ISQ_LAT-1]};
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      fin       = lb_ff[COR_LAT-1];
      valid_in  = vb_ff[COR_LAT-1];
      scalar_in = '0;
      cx_in     = '0;
      cy_in     = '0;
      cz_in     = '0;
      err_in    = 1'b0;
      unique case (fin.side.op)
         OP_DOT: begin
            scalar_in = fin.side.dot;
         end
         OP_CROSS: begin
            cx_in = fin.side.cx;
            cy_in = fin.side.cy;
            cz_in = fin.side.cz;
         end
         OP_NORM: begin
            scalar_in = $signed(33'(fin.norm));
         end
         OP_ANGLE: begin
            err_in    = fin.side.err;
            scalar_in = fin.side.err ? '0 : $signed(33'(angle));
         end
         default: begin
            scalar_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      scalar_ff <= scalar_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      cz_ff     <= cz_in;
      err_ff    <= err_in;
   end

   assign rsp_valid             = valid_ff;
   assign rsp_scalar_result     = scalar_ff;
   assign rsp_cross_x           = cx_ff;
   assign rsp_cross_y           = cy_ff;
   assign rsp_cross_z           = cz_ff;
   assign rsp_zero_vector_error = err_ff;

   `V3_ASSERT_IMP(a_rsp_follows_req, clock, reset, rsp_valid, $past(start, TOTAL_LAT), "result beat without a request beat at the pipeline latency")
   `V3_ASSERT_IMP(a_err_only_angle, clock, reset, rsp_valid && rsp_zero_vector_error, $past(req_opcode == OP_ANGLE, TOTAL_LAT), "zero-vector flag on a non-angle beat")
   `V3_ASSERT_NEVER(a_err_zero_fields, clock, reset, rsp_valid && rsp_zero_vector_error && (rsp_scalar_result != '0 || rsp_cross_x != '0), "zero-vector beat with non-zero fields")

endmodule
